// ===== rtl/cbr_pkg.sv =====
package cbr_pkg;

   // field widths
   localparam int CMD_W    = 2;
   localparam int BANK_W   = 4;
   localparam int OFFS_W   = 12;
   localparam int DATA_W   = 8;
   localparam int TGT_W    = 3;
   localparam int ADDR_W   = 20;
   localparam int MODE_W   = 2;
   localparam int PAGE_W   = 4;
   localparam int CHRPG_W  = 7;

   // fuse map capture
   localparam int FUSEMAP_BYTES = 4096;
   localparam int CNT_W         = $clog2(FUSEMAP_BYTES);

   // csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_TRAINER = 1'b0;

   // access commands
   localparam logic [CMD_W-1:0] CMD_CPU_RD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CPU_WR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PPU_RD = 2'd2;
   localparam logic [CMD_W-1:0] CMD_PPU_WR = 2'd3;

   // modes
   localparam logic [MODE_W-1:0] MODE_WAIT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PLAY = 2'd2;

   // routing targets
   localparam logic [TGT_W-1:0] TGT_NONE   = 3'd0;
   localparam logic [TGT_W-1:0] TGT_PASS   = 3'd1;
   localparam logic [TGT_W-1:0] TGT_MAPPER = 3'd2;
   localparam logic [TGT_W-1:0] TGT_PRGRAM = 3'd3;
   localparam logic [TGT_W-1:0] TGT_BIOS   = 3'd4;
   localparam logic [TGT_W-1:0] TGT_CHRRAM = 3'd5;
   localparam logic [TGT_W-1:0] TGT_REG    = 3'd6;
   localparam logic [TGT_W-1:0] TGT_FUSE   = 3'd7;

   // bank decode, and register decode in bank 4
   localparam logic [BANK_W-1:0] BANK_REG      = 4'h4;
   localparam logic [BANK_W-1:0] BANK_PRG_LO   = 4'h6;
   localparam logic [BANK_W-1:0] BANK_PRG_HI   = 4'hD;
   localparam logic [BANK_W-1:0] BANK_TRAINER  = 4'hE;
   localparam logic [OFFS_W-1:0] OFF_STATUS_A  = 12'h100;
   localparam logic [OFFS_W-1:0] OFF_STATUS_B  = 12'h101;
   localparam logic [OFFS_W-1:0] OFF_CTRL      = 12'h13F;
   localparam logic [OFFS_W-1:0] OFF_MAPPER    = 12'h2FC;
   localparam logic [OFFS_W-1:0] OFF_LOAD      = 12'h3FE;
   localparam logic [OFFS_W-1:0] OFF_LAUNCH    = 12'hFFF;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BANK_W-1:0] bank;
      logic [OFFS_W-1:0] offset;
      logic [DATA_W-1:0] data;
   } req_type;

   typedef struct packed {
      logic [TGT_W-1:0]  target;
      logic [ADDR_W-1:0] mem_address;
      logic              shadow_chr;
      logic [DATA_W-1:0] read_data;
      logic [MODE_W-1:0] mode;
      logic              mapper_reset;
      logic              fusemap_complete;
   } rsp_type;

endpackage

// ===== rtl/cbr_if.sv =====
interface cbr_req_if import cbr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BANK_W-1:0] bank;
   logic [OFFS_W-1:0] offset;
   logic [DATA_W-1:0] data;

   modport source (output valid, cmd, bank, offset, data, input ready);
   modport sink   (input valid, cmd, bank, offset, data, output ready);
endinterface

interface cbr_rsp_if import cbr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TGT_W-1:0]  target;
   logic [ADDR_W-1:0] mem_address;
   logic              shadow_chr;
   logic [DATA_W-1:0] read_data;
   logic [MODE_W-1:0] mode;
   logic              mapper_reset;
   logic              fusemap_complete;

   modport source (output valid, target, mem_address, shadow_chr, read_data, mode,
                   mapper_reset, fusemap_complete, input ready);
   modport sink   (input valid, target, mem_address, shadow_chr, read_data, mode,
                   mapper_reset, fusemap_complete, output ready);
endinterface

// ===== rtl/copier_bus_router_state_machine.sv =====
// Bus router for a game-copier adapter between console and cartridge.
// req_bus carries one CPU or PPU access per request (cmd, bank, offset,
// data); rsp_bus returns one routing result per request: target, flat
// address, chr shadow flag, status read data, mode and the mapper reset and
// fuse map complete pulses. Both are valid/ready channels.
// The csr port (psel/penable/pwrite, pready tied high) holds trainer_page at
// byte address 0; write it only while no request is in flight.
// A request is registered on acceptance, routed against the mode and page
// state once the result register is free or being taken, and its result
// registered there, from where rsp_bus offers it.
// One request per cycle is sustained while rsp_bus takes every result; the
// route logic is a single pass between the two registers.
// When rsp_bus stalls, the result register holds and the input register
// still takes one more request; req_bus.ready then drops until the result
// is taken.
// Reset clears the mode to waiting, the pages, status bytes, capture gate and
// capture count, and empties both registers.
module copier_bus_router_state_machine import cbr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cbr_req_if.sink               req_bus,
   cbr_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic              req_vld_ff, req_vld_in;
   req_type           req_pl_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   rsp_type           rsp_pl_ff;
   rsp_type           route_rsp;
   logic              fire;
   logic              take;
   logic [PAGE_W-1:0] trainer_page;

   cbr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .trainer_page (trainer_page)
   );

   cbr_route u_route (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .req          (req_pl_ff),
      .trainer_page (trainer_page),
      .rsp          (route_rsp)
   );

   assign fire          = req_vld_ff && (!rsp_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !req_vld_ff || fire;
   assign take          = req_bus.valid && req_bus.ready;

   assign req_vld_in = take || (req_vld_ff && !fire);
   assign rsp_vld_in = fire || (rsp_vld_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_pl_ff <= '{cmd: req_bus.cmd, bank: req_bus.bank,
                        offset: req_bus.offset, data: req_bus.data};
      end
      if (fire) begin
         rsp_pl_ff <= route_rsp;
      end
   end

   assign rsp_bus.valid            = rsp_vld_ff;
   assign rsp_bus.target           = rsp_pl_ff.target;
   assign rsp_bus.mem_address      = rsp_pl_ff.mem_address;
   assign rsp_bus.shadow_chr       = rsp_pl_ff.shadow_chr;
   assign rsp_bus.read_data        = rsp_pl_ff.read_data;
   assign rsp_bus.mode             = rsp_pl_ff.mode;
   assign rsp_bus.mapper_reset     = rsp_pl_ff.mapper_reset;
   assign rsp_bus.fusemap_complete = rsp_pl_ff.fusemap_complete;

endmodule

// ===== rtl/cbr_csr.sv =====
module cbr_csr import cbr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [PAGE_W-1:0]     trainer_page
);

   logic [PAGE_W-1:0] trainer_page_ff;
   logic [PAGE_W-1:0] trainer_page_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      trainer_page_in = trainer_page_ff;
      if (wr_en && paddr[2] == CSR_IDX_TRAINER) begin
         trainer_page_in = pwdata[PAGE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trainer_page_ff <= '0;
      end else begin
         trainer_page_ff <= trainer_page_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_TRAINER) begin
         prdata = {{(CSR_DATA_W-PAGE_W){1'b0}}, trainer_page_ff};
      end
   end

   assign trainer_page = trainer_page_ff;

endmodule

// ===== rtl/cbr_route.sv =====
module cbr_route import cbr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  req_type           req,
   input  logic [PAGE_W-1:0] trainer_page,
   output rsp_type           rsp
);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FUSEMAP_BYTES - 1);

   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [PAGE_W-1:0]  prg_page_ff, prg_page_in;
   logic [CHRPG_W-1:0] chr_page_ff, chr_page_in;
   logic [DATA_W-1:0]  status_a_ff, status_a_in;
   logic [DATA_W-1:0]  status_b_ff, status_b_in;
   logic               gate_ff, gate_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic              is_load, is_play, is_wait;
   logic              prg_bank, trn_bank, reg_bank, low_bank;
   logic [ADDR_W-1:0] prg_addr, trn_addr, bios_addr, chr_addr;
   logic [TGT_W-1:0]  dflt_tgt;

   assign is_wait  = (mode_ff == MODE_WAIT);
   assign is_load  = (mode_ff == MODE_LOAD);
   assign is_play  = (mode_ff == MODE_PLAY);
   assign reg_bank = (req.bank == BANK_REG);
   assign prg_bank = (req.bank >= BANK_PRG_LO) && (req.bank <= BANK_PRG_HI);
   assign trn_bank = (req.bank >= BANK_TRAINER);
   assign low_bank = !req.bank[BANK_W-1];
   assign dflt_tgt = is_play ? TGT_MAPPER : TGT_PASS;

   assign prg_addr  = {1'b0, prg_page_ff, req.bank[2:0], req.offset};
   assign trn_addr  = {1'b0, trainer_page, req.bank[2:0], req.offset};
   assign bios_addr = {6'd0, 1'b1, req.bank[0], req.offset};
   assign chr_addr  = {chr_page_ff, req.bank[2:0], req.offset[9:0]};

   always_comb begin
      rsp         = '0;
      mode_in     = mode_ff;
      prg_page_in = prg_page_ff;
      chr_page_in = chr_page_ff;
      status_a_in = status_a_ff;
      status_b_in = status_b_ff;
      gate_in     = gate_ff;
      count_in    = count_ff;

      case (req.cmd)
         CMD_CPU_RD: begin
            if (!is_wait && reg_bank) begin
               if (req.offset == OFF_STATUS_A) begin
                  rsp.target    = TGT_REG;
                  rsp.read_data = status_a_ff;
               end else if (req.offset == OFF_STATUS_B) begin
                  rsp.target    = TGT_REG;
                  rsp.read_data = status_b_ff;
               end else begin
                  rsp.target = TGT_PASS;
               end
            end else if (is_load && prg_bank) begin
               rsp.target      = TGT_PRGRAM;
               rsp.mem_address = prg_addr;
            end else if (is_load && trn_bank) begin
               rsp.target      = TGT_BIOS;
               rsp.mem_address = bios_addr;
            end else if (is_load) begin
               rsp.target = TGT_PASS;
            end else begin
               rsp.target = dflt_tgt;
            end
         end
         CMD_CPU_WR: begin
            if (!reg_bank) begin
               if (is_load && prg_bank) begin
                  rsp.target      = TGT_PRGRAM;
                  rsp.mem_address = prg_addr;
               end else if (is_load && trn_bank) begin
                  rsp.target      = TGT_PRGRAM;
                  rsp.mem_address = trn_addr;
               end else begin
                  rsp.target = dflt_tgt;
               end
            end else if (req.offset == OFF_STATUS_A) begin
               if (gate_ff) begin
                  rsp.target      = TGT_FUSE;
                  rsp.mem_address = ADDR_W'(count_ff);
                  if (count_ff == CNT_LAST) begin
                     count_in             = '0;
                     rsp.fusemap_complete = 1'b1;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  rsp.target = dflt_tgt;
               end
            end else if (req.offset == OFF_CTRL) begin
               if (is_play) begin
                  mode_in = MODE_LOAD;
               end
               gate_in = req.data[7];
               if (req.data[7]) begin
                  count_in = '0;
               end else begin
                  chr_page_in = req.data[CHRPG_W-1:0];
               end
               rsp.target = TGT_REG;
            end else if (req.offset[OFFS_W-1:2] == OFF_MAPPER[OFFS_W-1:2]) begin
               if (is_load) begin
                  mode_in = MODE_PLAY;
               end
               // bit 0 is kept, bit 3 follows the low address bit
               status_a_in = {req.data[7:4], req.offset[0], req.data[2:1], status_a_ff[0]};
               rsp.target  = TGT_MAPPER;
            end else if (req.offset[OFFS_W-1:1] == OFF_LOAD[OFFS_W-1:1]) begin
               status_a_in = {status_a_ff[7:4], 1'b1, status_a_ff[2:1], req.offset[0]};
               status_b_in = req.data;
               if (is_wait) begin
                  mode_in          = MODE_LOAD;
                  rsp.mapper_reset = 1'b1;
               end
               rsp.target  = is_play ? TGT_MAPPER : TGT_REG;
               prg_page_in = {req.data[2], req.data[3], req.data[5:4]};
            end else if (req.offset == OFF_LAUNCH) begin
               if (is_wait) begin
                  mode_in          = MODE_LOAD;
                  rsp.mapper_reset = 1'b1;
               end
               rsp.target = TGT_REG;
            end else begin
               rsp.target = dflt_tgt;
            end
         end
         default: begin
            // ppu side
            if (is_play) begin
               rsp.target = TGT_MAPPER;
            end else if (is_load && low_bank) begin
               rsp.target      = TGT_CHRRAM;
               rsp.mem_address = chr_addr;
            end else begin
               rsp.target = TGT_PASS;
               if (req.cmd == CMD_PPU_WR && is_wait && low_bank) begin
                  rsp.shadow_chr  = 1'b1;
                  rsp.mem_address = chr_addr;
               end
            end
         end
      endcase

      rsp.mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_WAIT;
         prg_page_ff <= '0;
         chr_page_ff <= '0;
         status_a_ff <= '0;
         status_b_ff <= '0;
         gate_ff     <= 1'b0;
         count_ff    <= '0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         prg_page_ff <= prg_page_in;
         chr_page_ff <= chr_page_in;
         status_a_ff <= status_a_in;
         status_b_ff <= status_b_in;
         gate_ff     <= gate_in;
         count_ff    <= count_in;
      end
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import cbr_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] TRAINER_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_TRAINER));
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR   = CSR_ADDR_W'(4);
   localparam logic [ADDR_W-1:0]     BIOS_BASE    = 20'h02000;
   localparam int                    SETTLE_CYCLES = 4;
   localparam int                    BASE_IDLE_PCT = 32;

   logic                  clock   = 1'b0;
   logic                  reset   = 1'b1;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cbr_req_if req_bus ();
   cbr_rsp_if rsp_bus ();

   copier_bus_router_state_machine dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // router state as the bench expects it
   logic [PAGE_W-1:0]  trainer_pg = '0;
   logic [PAGE_W-1:0]  prg_pg     = '0;
   logic [CHRPG_W-1:0] chr_pg     = '0;
   logic [MODE_W-1:0]  mode_q     = MODE_WAIT;
   logic [DATA_W-1:0]  stat_a     = '0;
   logic [DATA_W-1:0]  stat_b     = '0;
   logic               gate_open  = 1'b0;
   logic [CNT_W-1:0]   fuse_idx   = '0;

   rsp_type routes_due[$];
   int      errors          = 0;
   int      sender_idle_pct = BASE_IDLE_PCT;
   int      sink_idle_pct   = BASE_IDLE_PCT;
   int      hold_left       = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("copier_bus_router_state_machine: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (errors < 100) $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   function automatic logic [ADDR_W-1:0] prg_addr(input logic [PAGE_W-1:0] page,
                                                  input logic [BANK_W-1:0] bank,
                                                  input logic [OFFS_W-1:0] off);
      return ADDR_W'({page, bank[2:0], off});
   endfunction

   function automatic logic [ADDR_W-1:0] chr_addr(input logic [BANK_W-1:0] bank,
                                                  input logic [OFFS_W-1:0] off);
      return {chr_pg, bank[2:0], off[9:0]};
   endfunction

   function automatic logic play_or_mapper();
      return mode_q == MODE_PLAY;
   endfunction

   // routes one access and advances the mode, page, status and capture state
   function automatic rsp_type route_access(input req_type r);
      rsp_type o;
      logic    prg_bank;
      logic    high_bank;
      o         = '0;
      prg_bank  = r.bank >= BANK_PRG_LO && r.bank <= BANK_PRG_HI;
      high_bank = r.bank >= BANK_TRAINER;
      case (r.cmd)
         CMD_CPU_RD: begin
            if (mode_q != MODE_WAIT && r.bank == BANK_REG) begin
               if (r.offset == OFF_STATUS_A) begin
                  o.target    = TGT_REG;
                  o.read_data = stat_a;
               end else if (r.offset == OFF_STATUS_B) begin
                  o.target    = TGT_REG;
                  o.read_data = stat_b;
               end else begin
                  o.target = TGT_PASS;
               end
            end else if (mode_q == MODE_LOAD && prg_bank) begin
               o.target      = TGT_PRGRAM;
               o.mem_address = prg_addr(prg_pg, r.bank, r.offset);
            end else if (mode_q == MODE_LOAD && high_bank) begin
               o.target      = TGT_BIOS;
               o.mem_address = BIOS_BASE | ADDR_W'({r.bank[0], r.offset});
            end else begin
               o.target = play_or_mapper() ? TGT_MAPPER : TGT_PASS;
            end
         end
         CMD_CPU_WR: begin
            if (r.bank != BANK_REG) begin
               if (mode_q == MODE_LOAD && prg_bank) begin
                  o.target      = TGT_PRGRAM;
                  o.mem_address = prg_addr(prg_pg, r.bank, r.offset);
               end else if (mode_q == MODE_LOAD && high_bank) begin
                  o.target      = TGT_PRGRAM;
                  o.mem_address = prg_addr(trainer_pg, r.bank, r.offset);
               end else begin
                  o.target = play_or_mapper() ? TGT_MAPPER : TGT_PASS;
               end
            end else if (r.offset == OFF_STATUS_A) begin
               if (gate_open) begin
                  o.target      = TGT_FUSE;
                  o.mem_address = ADDR_W'(fuse_idx);
                  if (int'(fuse_idx) + 1 >= FUSEMAP_BYTES) begin
                     fuse_idx           = '0;
                     o.fusemap_complete = 1'b1;
                  end else begin
                     fuse_idx++;
                  end
               end else begin
                  o.target = play_or_mapper() ? TGT_MAPPER : TGT_PASS;
               end
            end else if (r.offset == OFF_CTRL) begin
               if (mode_q == MODE_PLAY) mode_q = MODE_LOAD;
               gate_open = r.data[7];
               if (gate_open) fuse_idx = '0;
               else chr_pg = r.data[6:0];
               o.target = TGT_REG;
            end else if (r.offset[11:2] == OFF_MAPPER[11:2]) begin
               if (mode_q == MODE_LOAD) mode_q = MODE_PLAY;
               stat_a   = {r.data[7:4], r.offset[0], r.data[2:1], stat_a[0]};
               o.target = TGT_MAPPER;
            end else if (r.offset[11:1] == OFF_LOAD[11:1]) begin
               stat_a = {stat_a[7:4], r.offset[3], stat_a[2:1], r.offset[0]};
               stat_b = r.data;
               if (mode_q == MODE_WAIT) begin
                  mode_q         = MODE_LOAD;
                  o.mapper_reset = 1'b1;
               end
               o.target = play_or_mapper() ? TGT_MAPPER : TGT_REG;
               prg_pg   = {r.data[2], r.data[3], r.data[5:4]};
            end else if (r.offset == OFF_LAUNCH) begin
               if (mode_q == MODE_WAIT) begin
                  mode_q         = MODE_LOAD;
                  o.mapper_reset = 1'b1;
               end
               o.target = TGT_REG;
            end else begin
               o.target = play_or_mapper() ? TGT_MAPPER : TGT_PASS;
            end
         end
         default: begin
            if (mode_q == MODE_PLAY) begin
               o.target = TGT_MAPPER;
            end else if (mode_q == MODE_LOAD) begin
               if (!r.bank[3]) begin
                  o.target      = TGT_CHRRAM;
                  o.mem_address = chr_addr(r.bank, r.offset);
               end else begin
                  o.target = TGT_PASS;
               end
            end else begin
               o.target = TGT_PASS;
               // waiting mode mirrors pattern-table writes into chr ram
               if (r.cmd == CMD_PPU_WR && !r.bank[3]) begin
                  o.shadow_chr  = 1'b1;
                  o.mem_address = chr_addr(r.bank, r.offset);
               end
            end
         end
      endcase
      o.mode = mode_q;
      return o;
   endfunction

   function automatic req_type access(input logic [CMD_W-1:0] cmd,
                                      input logic [BANK_W-1:0] bank,
                                      input logic [OFFS_W-1:0] offset,
                                      input logic [DATA_W-1:0] data);
      req_type r;
      r.cmd    = cmd;
      r.bank   = bank;
      r.offset = offset;
      r.data   = data;
      return r;
   endfunction

   // 35 percent of requests hit the decoded registers in bank 4
   function automatic req_type random_access(input bit allow_launch);
      req_type r;
      int      pick;
      r.cmd    = CMD_W'($urandom_range(3));
      r.bank   = BANK_W'($urandom_range(15));
      r.offset = OFFS_W'($urandom_range(4095));
      r.data   = DATA_W'($urandom_range(255));
      pick     = $urandom_range(99);
      if (pick < 35) begin
         r.bank = BANK_REG;
         case ($urandom_range(11))
            0:       r.offset = OFF_STATUS_A;
            1:       r.offset = OFF_STATUS_B;
            2, 3, 4: r.offset = OFF_CTRL;
            5:       r.offset = OFF_MAPPER;
            6:       r.offset = OFF_MAPPER + OFFS_W'(1);
            7:       r.offset = OFF_MAPPER + OFFS_W'(2);
            8:       r.offset = OFF_MAPPER + OFFS_W'(3);
            9:       r.offset = OFF_LOAD;
            10:      r.offset = OFF_LOAD + OFFS_W'(1);
            default: r.offset = OFF_LAUNCH;
         endcase
      end else if (pick < 45) begin
         r.bank = BANK_REG;
      end
      if (!allow_launch && r.cmd == CMD_CPU_WR && r.bank == BANK_REG &&
          (r.offset[11:1] == OFF_LOAD[11:1] || r.offset == OFF_LAUNCH))
         r.offset = OFF_STATUS_A;
      return r;
   endfunction

   task automatic send_access(input req_type r);
      rsp_type due;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.cmd    <= r.cmd;
      req_bus.bank   <= r.bank;
      req_bus.offset <= r.offset;
      req_bus.data   <= r.data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      due        = route_access(r);
      routes_due = {routes_due, due};
   endtask

   task automatic drain_routes();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (routes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr == TRAINER_ADDR) trainer_pg = value[PAGE_W-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_trainer();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= TRAINER_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      check_field("trainer_page readback", prdata, CSR_DATA_W'(trainer_pg));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // results are compared in order against the predicted routes
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (routes_due.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = routes_due.pop_front();
            check_field("target", 32'(rsp_bus.target), 32'(want.target));
            check_field("mem_address", 32'(rsp_bus.mem_address), 32'(want.mem_address));
            check_field("shadow_chr", 32'(rsp_bus.shadow_chr), 32'(want.shadow_chr));
            check_field("read_data", 32'(rsp_bus.read_data), 32'(want.read_data));
            check_field("mode", 32'(rsp_bus.mode), 32'(want.mode));
            check_field("mapper_reset", 32'(rsp_bus.mapper_reset), 32'(want.mapper_reset));
            check_field("fusemap_complete", 32'(rsp_bus.fusemap_complete),
                        32'(want.fusemap_complete));
         end
      end
   end

   // receiver: random stalls, plus a counted hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   task automatic test_csr_access();
      check_trainer();
      csr_write(TRAINER_ADDR, 32'hFFFF_FFFF);
      check_trainer();
      csr_write(SPARE_ADDR, 32'h0000_0000);
      check_trainer();
   endtask

   task automatic test_waiting_routes();
      send_access(access(CMD_PPU_WR, 4'h0, 12'h000, 8'h00));
      send_access(access(CMD_PPU_WR, 4'h7, 12'hFFF, 8'hFF));
      send_access(access(CMD_PPU_WR, 4'h8, 12'h000, 8'h11));
      send_access(access(CMD_PPU_RD, 4'h3, 12'h3FF, 8'h00));
      send_access(access(CMD_CPU_RD, BANK_REG, OFF_STATUS_A, 8'h00));
      send_access(access(CMD_CPU_RD, 4'hE, 12'hFFF, 8'h00));
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_MAPPER + OFFS_W'(1), 8'hFF));
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_CTRL, 8'h7F));
      send_access(access(CMD_PPU_WR, 4'h5, 12'h155, 8'h5A));
      // short capture with the gate open, then closed again
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_CTRL, 8'h80));
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_STATUS_A, 8'hA5));
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_STATUS_A, 8'h5A));
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_CTRL, 8'h00));
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_STATUS_A, 8'h33));
      // waiting mode cannot be re-entered, so cover it now
      repeat (60) send_access(random_access(1'b0));
   endtask

   task automatic test_loading_routes();
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_LOAD, 8'hFF));
      send_access(access(CMD_CPU_RD, BANK_REG, OFF_STATUS_A, 8'h00));
      send_access(access(CMD_CPU_RD, BANK_REG, OFF_STATUS_B, 8'h00));
      send_access(access(CMD_CPU_RD, BANK_REG, 12'h200, 8'h00));
      send_access(access(CMD_CPU_WR, BANK_PRG_LO, 12'h000, 8'h01));
      send_access(access(CMD_CPU_WR, BANK_PRG_HI, 12'hFFF, 8'h02));
      send_access(access(CMD_CPU_WR, BANK_TRAINER, 12'h123, 8'h03));
      send_access(access(CMD_CPU_WR, 4'hF, 12'hFFF, 8'h04));
      send_access(access(CMD_CPU_RD, 4'hF, 12'h800, 8'h00));
      send_access(access(CMD_PPU_RD, 4'h7, 12'h3FF, 8'h00));
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_LOAD + OFFS_W'(1), 8'h00));
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_LAUNCH, 8'h00));
   endtask

   task automatic test_play_routes();
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_MAPPER, 8'h00));
      send_access(access(CMD_CPU_RD, BANK_REG, OFF_STATUS_B, 8'h00));
      send_access(access(CMD_CPU_RD, 4'h8, 12'h000, 8'h00));
      send_access(access(CMD_CPU_WR, 4'h8, 12'hABC, 8'h77));
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_LOAD + OFFS_W'(1), 8'h3C));
      // back to loading without a mapper reset
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_CTRL, 8'h12));
   endtask

   task automatic test_fusemap_capture();
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_CTRL, 8'h80));
      repeat (FUSEMAP_BYTES + 3)
         send_access(access(CMD_CPU_WR, BANK_REG, OFF_STATUS_A, DATA_W'($urandom)));
      // reopening mid-count restarts the index
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_CTRL, 8'hFF));
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_STATUS_A, 8'hC3));
      send_access(access(CMD_CPU_WR, BANK_REG, OFF_CTRL, {1'b0, 7'($urandom)}));
   endtask

   task automatic test_backpressure();
      hold_left       = 300;
      sender_idle_pct = 0;
      repeat (40) send_access(random_access(1'b1));
      sender_idle_pct = BASE_IDLE_PCT;
      drain_routes();
   endtask

   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0] page_word;
      for (int p = 0; p < 6; p++) begin
         drain_routes();
         case (p)
            0:       page_word = '0;
            1:       page_word = 32'hFFFF_FFFF;
            default: page_word = $urandom;
         endcase
         csr_write(TRAINER_ADDR, page_word);
         check_trainer();
         sender_idle_pct = (p == 2) ? 0 : BASE_IDLE_PCT;
         sink_idle_pct   = (p == 2) ? 0 : BASE_IDLE_PCT;
         repeat (200) send_access(random_access(1'b1));
      end
      sender_idle_pct = BASE_IDLE_PCT;
      sink_idle_pct   = BASE_IDLE_PCT;
   endtask

   initial begin
      req_bus.valid  = 1'b0;
      req_bus.cmd    = CMD_CPU_RD;
      req_bus.bank   = '0;
      req_bus.offset = '0;
      req_bus.data   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_csr_access();
      test_waiting_routes();
      test_loading_routes();
      test_play_routes();
      drain_routes();
      test_fusemap_capture();
      test_backpressure();
      test_random_traffic();
      drain_routes();

      if (errors == 0) begin
         $display("copier_bus_router_state_machine: match");
      end else begin
         $display("copier_bus_router_state_machine: mismatch");
      end
      $finish;
   end

endmodule
